>>> rtl/core/lfg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfg_pkg
// Shared constants, types and a helper function of the lagged Fibonacci
// uniform generator.
// ---------------------------------------------------------------------------
package lfg_pkg;

  localparam int BITS_DEF  = 24;
  localparam int BITS_MIN  = 24;
  localparam int SEED_W    = 31;
  localparam int VALUE_W   = 24;
  localparam int LAG_DEPTH = 97;
  localparam int LAG_AW    = 7;
  localparam int SMALL_W   = 8;
  localparam int PROD_W    = 15;
  localparam int QHI_W     = 17;
  localparam int HI_SHIFT  = 46;
  localparam int SM_SHIFT  = 23;

  localparam logic [LAG_AW-1:0] LONG_START  = LAG_AW'(96);
  localparam logic [LAG_AW-1:0] SHORT_START = LAG_AW'(32);
  localparam logic [LAG_AW-1:0] LAG_LAST    = LAG_AW'(LAG_DEPTH - 1);

  localparam logic [14:0] DIV_HI = 15'd30082;
  localparam logic [14:0] MOD_HI = 15'd31329;
  localparam logic [14:0] DIV_A  = 15'd177;
  localparam logic [14:0] DIV_C  = 15'd169;

  localparam logic [31:0] RCP_HI = 32'((64'd1 << HI_SHIFT) / 64'(DIV_HI) + 64'd1);
  localparam logic [15:0] RCP_A  = 16'((32'd1 << SM_SHIFT) / 32'(DIV_A) + 32'd1);
  localparam logic [15:0] RCP_C  = 16'((32'd1 << SM_SHIFT) / 32'(DIV_C) + 32'd1);

  localparam logic [SMALL_W-1:0] MOD_M = 8'd179;
  localparam logic [SMALL_W-1:0] MOD_D = 8'd169;
  localparam logic [SMALL_W-1:0] MUL_D = 8'd53;

  localparam logic [23:0] CARRY_INIT_BASE = 24'd362436;
  localparam logic [23:0] CARRY_STEP_BASE = 24'd7654321;
  localparam logic [23:0] CARRY_MOD_BASE  = 24'd16777213;

  typedef struct packed {
    logic busy;
    logic done;
  } seed_stat_t;

  function automatic logic [SMALL_W-1:0] mod_reduce(input logic [PROD_W-1:0] x,
                                                    input logic [SMALL_W-1:0] m);
    logic [PROD_W-1:0] v;
    logic [PROD_W-1:0] sub;
    v = x;
    for (int k = 7; k >= 0; k--) begin
      sub = PROD_W'({7'd0, m} << k);
      if (v >= sub) begin
        v = v - sub;
      end
    end
    return v[SMALL_W-1:0];
  endfunction

endpackage

>>> rtl/core/lagged_fibonacci_uniform_generator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lagged_fibonacci_uniform_generator_unit
// Lagged Fibonacci uniform generator with arithmetic-sequence carry.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. mode 0 seeds the generator from seed and refills the
//   97-entry lag table; mode 1 draws one number.
//   Result channel: done is high for exactly one cycle with value holding
//   the nonzero draw; the fraction is value / 2^BITS. The receiver cannot
//   stall this channel.
//   Draw: one attempt reads two table entries (registered RAM read), writes
//   the difference back and subtracts the carry in states READ, SUB and
//   CHECK. busy stays high through these states; done is raised in the next
//   cycle, as busy drops, once the draw is nonzero. A zero draw repeats the
//   attempt.
//   Seed: states HQ, HM, LO, AQ, AM, BC, CM and DR split the seed by
//   reciprocal multiplication, then each of the 97 x BITS table bits is formed
//   by passes through the shared multiply / reduce unit; busy stays high until
//   the seed sequencer reports done. No result.
//   A draw before the first seed returns no result and changes nothing.
//   Reset: idle, unseeded, pointers at 96 and 32, carry cleared; the lag
//   table is left as is and is fully rewritten by each seed.
// ---------------------------------------------------------------------------
module lagged_fibonacci_uniform_generator_unit #(
  parameter int BITS = lfg_pkg::BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [lfg_pkg::SEED_W-1:0]  seed,
  output logic                        done,
  output logic [lfg_pkg::VALUE_W-1:0] value
);
  import lfg_pkg::*;

  localparam int SCALE = BITS - BITS_MIN;
  localparam logic [BITS-1:0] CARRY_INIT = BITS'(CARRY_INIT_BASE) << SCALE;
  localparam logic [BITS-1:0] CARRY_STEP = BITS'(CARRY_STEP_BASE) << SCALE;
  localparam logic [BITS-1:0] CARRY_WRAP =
    BITS'(CARRY_MOD_BASE - CARRY_STEP_BASE) << SCALE;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEED, ST_READ, ST_SUB, ST_CHECK
  } state_t;

  state_t            state;
  logic [LAG_AW-1:0] lp;
  logic [LAG_AW-1:0] sp;
  logic [BITS-1:0]   carry;
  logic              seeded;
  logic [BITS-1:0]   diff;

  logic              accept;
  logic              seed_go;
  seed_stat_t        seed_stat;
  logic              seed_we;
  logic [LAG_AW-1:0] seed_addr;
  logic [BITS-1:0]   seed_data;

  logic              ram_we;
  logic [LAG_AW-1:0] ram_waddr;
  logic [BITS-1:0]   ram_wdata;
  logic [BITS-1:0]   rd_long;
  logic [BITS-1:0]   rd_short;
  logic [BITS-1:0]   diff_next;
  logic [BITS-1:0]   carry_next;
  logic [BITS-1:0]   result;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign seed_go = accept && !mode;

  lfg_seed #(
    .BITS(BITS)
  ) u_seed (
    .clk     (clk),
    .rst     (rst),
    .go      (seed_go),
    .seed    (seed),
    .stat    (seed_stat),
    .wr_en   (seed_we),
    .wr_addr (seed_addr),
    .wr_data (seed_data)
  );

  always_comb begin
    diff_next  = rd_long - rd_short;
    carry_next = (carry < CARRY_STEP) ? carry + CARRY_WRAP : carry - CARRY_STEP;
    result     = diff - carry;
    if (state == ST_SUB) begin
      ram_we    = 1'b1;
      ram_waddr = lp;
      ram_wdata = diff_next;
    end else begin
      ram_we    = seed_we;
      ram_waddr = seed_addr;
      ram_wdata = seed_data;
    end
  end

  lfg_ram #(
    .WIDTH(BITS),
    .DEPTH(LAG_DEPTH)
  ) u_lag (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (lp),
    .rdata_a (rd_long),
    .raddr_b (sp),
    .rdata_b (rd_short)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      lp     <= LONG_START;
      sp     <= SHORT_START;
      carry  <= '0;
      seeded <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!mode) begin
              lp     <= LONG_START;
              sp     <= SHORT_START;
              carry  <= CARRY_INIT;
              seeded <= 1'b1;
              state  <= ST_SEED;
            end else if (seeded) begin
              state <= ST_READ;
            end
          end
        end
        ST_SEED: begin
          if (seed_stat.done) begin
            state <= ST_IDLE;
          end
        end
        ST_READ: state <= ST_SUB;
        ST_SUB: begin
          diff  <= diff_next;
          lp    <= (lp == '0) ? LAG_LAST : lp - LAG_AW'(1);
          sp    <= (sp == '0) ? LAG_LAST : sp - LAG_AW'(1);
          carry <= carry_next;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (result != '0) begin
            value <= result[VALUE_W-1:0];
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_seed_tracks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEED) |-> (seed_stat.busy || seed_stat.done))
    else $error("seed sequencer idle while seeding");

  a_lag_gap: assert property (@(posedge clk) disable iff (rst)
    (lp == sp + LAG_AW'(64)) || (sp == lp + LAG_AW'(33)))
    else $error("lag pointers out of step");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_seed_only_idle: assert property (@(posedge clk) disable iff (rst)
    seed_stat.busy |-> (state == ST_SEED))
    else $error("seed sequencer active outside seeding");

endmodule

>>> rtl/core/lfg_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfg_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module lfg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 97
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/core/lfg_seed.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfg_seed
// Seed sequencer: splits the seed by reciprocal multiplication, then fills
// the lag table one bit at a time through a shared multiply / reduce unit.
// ---------------------------------------------------------------------------
module lfg_seed #(
  parameter int BITS = lfg_pkg::BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [lfg_pkg::SEED_W-1:0]  seed,
  output lfg_pkg::seed_stat_t         stat,
  output logic                        wr_en,
  output logic [lfg_pkg::LAG_AW-1:0]  wr_addr,
  output logic [BITS-1:0]             wr_data
);
  import lfg_pkg::*;

  localparam int BW = $clog2(BITS);
  localparam logic [BW-1:0] BIT_LAST = BW'(BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_HQ, S_HM, S_LO, S_AQ, S_AM, S_BC, S_CM, S_DR,
    S_AB, S_RA, S_TC, S_RC, S_DM, S_RD, S_BIT
  } state_t;

  state_t             state;
  logic [SEED_W-1:0]  x;
  logic [63:0]        sprod;
  logic [QHI_W-1:0]   q1;
  logic [14:0]        lo;
  logic [14:0]        hi;
  logic [SMALL_W-1:0] a, b, c, d, t;
  logic [PROD_W-1:0]  prod;
  logic [BW-1:0]      bitcnt;
  logic [LAG_AW-1:0]  entry;
  logic [BITS-1:0]    acc;
  logic               done;

  logic [31:0]        mx, my;
  logic [63:0]        sprod_next;
  logic [QHI_W-1:0]   hi_red;
  logic [SMALL_W-1:0] mul_x, mul_y;
  logic               mul_add;
  logic [PROD_W-1:0]  prod_next;
  logic [SMALL_W-1:0] red;
  logic [5:0]         bprod;
  logic [BITS-1:0]    acc_next;

  always_comb begin
    mx = '0;
    my = '0;
    case (state)
      S_HQ: begin
        mx = 32'(x);
        my = RCP_HI;
      end
      S_HM: begin
        mx = 32'(sprod[HI_SHIFT +: QHI_W]);
        my = 32'(DIV_HI);
      end
      S_AQ: begin
        mx = 32'(hi);
        my = 32'(RCP_A);
      end
      S_AM: begin
        mx = 32'(sprod[SM_SHIFT +: SMALL_W]);
        my = 32'(DIV_A);
      end
      S_BC: begin
        mx = 32'(lo);
        my = 32'(RCP_C);
      end
      S_CM: begin
        mx = 32'(sprod[SM_SHIFT +: SMALL_W]);
        my = 32'(DIV_C);
      end
      default: ;
    endcase
    sprod_next = {32'd0, mx} * {32'd0, my};
    if (q1 >= {1'b0, MOD_HI, 1'b0}) begin
      hi_red = q1 - {1'b0, MOD_HI, 1'b0};
    end else if (q1 >= {2'b00, MOD_HI}) begin
      hi_red = q1 - {2'b00, MOD_HI};
    end else begin
      hi_red = q1;
    end
  end

  always_comb begin
    mul_x   = a;
    mul_y   = b;
    mul_add = 1'b0;
    case (state)
      S_TC: begin
        mul_x = t;
        mul_y = c;
      end
      S_DM: begin
        mul_x   = MUL_D;
        mul_y   = d;
        mul_add = 1'b1;
      end
      default: ;
    endcase
    prod_next = PROD_W'(16'(mul_x) * 16'(mul_y)) + PROD_W'(mul_add);
    red       = mod_reduce(prod, (state == S_RD) ? MOD_D : MOD_M);
    bprod     = d[5:0] * c[5:0];
    acc_next  = {acc[BITS-2:0], bprod[5]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      done  <= 1'b0;
      wr_en <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            x     <= seed;
            state <= S_HQ;
          end
        end
        S_HQ: begin
          sprod <= sprod_next;
          state <= S_HM;
        end
        S_HM: begin
          q1    <= sprod[HI_SHIFT +: QHI_W];
          sprod <= sprod_next;
          state <= S_LO;
        end
        S_LO: begin
          lo    <= 15'(x - sprod[SEED_W-1:0]);
          hi    <= 15'(hi_red);
          state <= S_AQ;
        end
        S_AQ: begin
          sprod <= sprod_next;
          state <= S_AM;
        end
        S_AM: begin
          a     <= sprod[SM_SHIFT +: SMALL_W] + 8'd2;
          sprod <= sprod_next;
          state <= S_BC;
        end
        S_BC: begin
          b     <= 8'(hi - sprod[14:0]) + 8'd2;
          sprod <= sprod_next;
          state <= S_CM;
        end
        S_CM: begin
          c     <= sprod[SM_SHIFT +: SMALL_W] + 8'd1;
          sprod <= sprod_next;
          state <= S_DR;
        end
        S_DR: begin
          d      <= 8'(lo - sprod[14:0]);
          bitcnt <= '0;
          entry  <= '0;
          state  <= S_AB;
        end
        S_AB: begin
          prod  <= prod_next;
          state <= S_RA;
        end
        S_RA: begin
          t     <= red;
          state <= S_TC;
        end
        S_TC: begin
          prod  <= prod_next;
          state <= S_RC;
        end
        S_RC: begin
          a     <= b;
          b     <= c;
          c     <= red;
          state <= S_DM;
        end
        S_DM: begin
          prod  <= prod_next;
          state <= S_RD;
        end
        S_RD: begin
          d     <= red;
          state <= S_BIT;
        end
        S_BIT: begin
          acc    <= acc_next;
          bitcnt <= bitcnt + BW'(1);
          state  <= S_AB;
          if (bitcnt == BIT_LAST) begin
            bitcnt  <= '0;
            wr_en   <= 1'b1;
            wr_addr <= entry;
            wr_data <= acc_next;
            entry   <= entry + LAG_AW'(1);
            if (entry == LAG_LAST) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = done;

endmodule

>>> test/tb_lagged_fibonacci_uniform_generator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lagged_fibonacci_uniform_generator_unit
// Self-checking bench for the lagged Fibonacci uniform generator. A driver
// issues seed and draw transactions from a queue and predicts every draw with
// its own copy of the lag table, pointers and carry. A monitor compares each
// done strobe with the oldest predicted value. A directed run covers draws
// before the first seed and seeds at the field and split extremes; a random
// run follows with mostly draws and an occasional reseed, under three sender
// idling phases.
// ---------------------------------------------------------------------------
module tb_lagged_fibonacci_uniform_generator_unit;

  localparam int BITS        = lfg_pkg::BITS_DEF;
  localparam int SCALE       = BITS - 24;
  localparam int RAND_ITEMS  = 730;
  localparam int STALL_LIMIT = 100000;
  localparam int TAIL_CYCLES = 20;

  typedef logic [BITS-1:0] word_t;

  typedef struct packed {
    logic                       mode;
    logic [lfg_pkg::SEED_W-1:0] seed;
  } gen_cmd_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        mode = 1'b0;
  logic [lfg_pkg::SEED_W-1:0]  seed = '0;
  logic                        done;
  logic [lfg_pkg::VALUE_W-1:0] value;

  gen_cmd_t                    pending_cmds[$];
  logic [lfg_pkg::VALUE_W-1:0] expected_values[$];
  gen_cmd_t                    next_cmd;
  logic [lfg_pkg::VALUE_W-1:0] want_value;
  int                          total_cmds;
  int                          issued_cmds = 0;
  int                          err_count = 0;
  int                          stall_cycles = 0;
  bit                          timed_out = 1'b0;

  word_t       lag_mem [lfg_pkg::LAG_DEPTH];
  int unsigned long_ptr = 96;
  int unsigned short_ptr = 32;
  word_t       carry_acc = '0;
  bit          seeded = 1'b0;

  lagged_fibonacci_uniform_generator_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .mode (mode),
    .seed (seed),
    .done (done),
    .value(value)
  );

  always #1 clk = ~clk;

  function automatic void refill_table(input logic [lfg_pkg::SEED_W-1:0] s);
    longint unsigned hi, lo, a, b, c, d, m;
    word_t acc;
    int e, k;
    hi = (longint'(s) / 30082) % 31329;
    lo = longint'(s) % 30082;
    a = (hi / 177) % 177 + 2;
    b = hi % 177 + 2;
    c = (lo / 169) % 178 + 1;
    d = lo % 169;
    for (e = 0; e < lfg_pkg::LAG_DEPTH; e++) begin
      acc = '0;
      for (k = BITS - 1; k >= 0; k--) begin
        m = (((a * b) % 179) * c) % 179;
        a = b;
        b = c;
        c = m;
        d = (53 * d + 1) % 169;
        if (((d * m) % 64) >= 32) begin
          acc[k] = 1'b1;
        end
      end
      lag_mem[e] = acc;
    end
    carry_acc  = word_t'(lfg_pkg::CARRY_INIT_BASE) << SCALE;
    long_ptr   = 96;
    short_ptr  = 32;
    seeded     = 1'b1;
  endfunction

  function automatic logic [lfg_pkg::VALUE_W-1:0] draw_number();
    word_t r;
    word_t step;
    word_t modulus;
    step    = word_t'(lfg_pkg::CARRY_STEP_BASE) << SCALE;
    modulus = word_t'(lfg_pkg::CARRY_MOD_BASE) << SCALE;
    do begin
      r = lag_mem[long_ptr] - lag_mem[short_ptr];
      lag_mem[long_ptr] = r;
      long_ptr  = (long_ptr == 0) ? 96 : long_ptr - 1;
      short_ptr = (short_ptr == 0) ? 96 : short_ptr - 1;
      if (carry_acc < step) begin
        carry_acc = carry_acc + modulus - step;
      end else begin
        carry_acc = carry_acc - step;
      end
      r = r - carry_acc;
    end while (r == '0);
    return r[lfg_pkg::VALUE_W-1:0];
  endfunction

  task automatic apply_cmd(input logic m, input logic [lfg_pkg::SEED_W-1:0] s);
    if (m == 1'b0) begin
      refill_table(s);
    end else if (seeded) begin
      expected_values.push_back(draw_number());
    end
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("[%0t] mismatch: %s: value got %0d want %0d", $time, what, got, want);
    err_count++;
  endtask

  function automatic int sender_idle_pct();
    if (issued_cmds < total_cmds / 3) begin
      return 9;
    end else if (issued_cmds < (2 * total_cmds) / 3) begin
      return 81;
    end
    return 0;
  endfunction

  function automatic gen_cmd_t make_cmd(input logic m, input logic [30:0] s);
    gen_cmd_t t;
    t.mode = m;
    t.seed = s;
    return t;
  endfunction

  // Driver: predict on acceptance, then present the next transaction.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      mode  <= 1'b0;
      seed  <= '0;
    end else begin
      if (start && !busy) begin
        apply_cmd(mode, seed);
      end
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          next_cmd = pending_cmds.pop_front();
          issued_cmds++;
          start <= 1'b1;
          mode  <= next_cmd.mode;
          seed  <= next_cmd.seed;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: match each strobe against the oldest predicted draw.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_values.size() == 0) begin
        report_mismatch("result with no pending draw", value, '0);
      end else begin
        want_value = expected_values.pop_front();
        if (value !== want_value) begin
          report_mismatch("draw", value, want_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      timed_out <= 1'b1;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // Draws ahead of the first seed give nothing.
    pending_cmds.push_back(make_cmd(1'b1, 31'h7FFF_FFFF));
    pending_cmds.push_back(make_cmd(1'b1, 31'h0));
    pending_cmds.push_back(make_cmd(1'b0, 31'h0));
    repeat (5) pending_cmds.push_back(make_cmd(1'b1, 31'($urandom())));
    pending_cmds.push_back(make_cmd(1'b0, 31'h7FFF_FFFF));
    repeat (5) pending_cmds.push_back(make_cmd(1'b1, 31'($urandom())));
    // Largest split: both small seeds at their top values.
    pending_cmds.push_back(make_cmd(1'b0, 31'(30082 * 31329 - 1)));
    repeat (4) pending_cmds.push_back(make_cmd(1'b1, 31'h7FFF_FFFF));
    // Split wraps back to zero.
    pending_cmds.push_back(make_cmd(1'b0, 31'(30082 * 31329)));
    repeat (4) pending_cmds.push_back(make_cmd(1'b1, 31'h0));
    repeat (RAND_ITEMS) begin
      if ($urandom_range(149) == 0) begin
        pending_cmds.push_back(make_cmd(1'b0, 31'($urandom())));
      end else begin
        pending_cmds.push_back(make_cmd(1'b1, 31'($urandom())));
      end
    end
    total_cmds = pending_cmds.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (!timed_out && !(pending_cmds.size() == 0 && !start && busy === 1'b0
                           && expected_values.size() == 0)) begin
      @(posedge clk);
    end
    if (!timed_out) begin
      repeat (TAIL_CYCLES) @(posedge clk);
    end

    if (!timed_out && err_count == 0 && expected_values.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
